[hdl/wfps_pkg.sv]
// shared types and constants of the wall-following pid steering block
// register map, configuration struct, controller commands and states
// no dependencies
package wfps_pkg;

	localparam int DEF_MAX_SCAN_SAMPLES = 2048;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int WIN_W  = 12;

	localparam logic [15:0] RST_SETPOINT   = 16'd384;
	localparam logic [7:0]  RST_HORIZON    = 8'd80;
	localparam logic [15:0] RST_GAIN_P     = 16'd20480;
	localparam logic [15:0] RST_GAIN_D     = 16'd20480;
	localparam logic [15:0] RST_GAIN_I     = 16'd205;
	localparam logic [31:0] RST_MOVE_THR   = 32'd655;
	localparam logic [11:0] RST_WIN_START  = 12'd135;
	localparam logic [11:0] RST_WIN_END    = 12'd404;

	// derivative term divisor, digit-serial divider geometry
	localparam int DERIV_DIV   = 25;
	localparam int DIV_REM_W   = $clog2(DERIV_DIV);
	localparam int DIV_DIGIT_W = 6;
	localparam int DIV_W       = 42;
	localparam int DIV_STEPS   = DIV_W / DIV_DIGIT_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		REG_SETPOINT  = 3'd0,
		REG_HORIZON   = 3'd1,
		REG_GAIN_P    = 3'd2,
		REG_GAIN_D    = 3'd3,
		REG_GAIN_I    = 3'd4,
		REG_MOVE_THR  = 3'd5,
		REG_WIN_START = 3'd6,
		REG_WIN_END   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0]      setpoint_distance;
		logic [7:0]       predict_horizon;
		logic [15:0]      gain_p;
		logic [15:0]      gain_d;
		logic [15:0]      gain_i;
		logic [31:0]      moving_threshold_sq;
		logic [WIN_W-1:0] window_start;
		logic [WIN_W-1:0] window_end;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ODOM,
		ST_PRED,
		ST_ERR,
		ST_MUL,
		ST_IMUL,
		ST_DIV,
		ST_SUM
	} state_t;

	typedef struct packed {
		logic sample;
		logic odom_ld;
		logic odom_cmp;
		logic pred;
		logic err;
		logic mul;
		logic imul;
		logic div_step;
		logic sum;
	} dp_cmd_t;

	typedef struct packed {
		logic out_full;
	} dp_status_t;

endpackage

[hdl/wfps_regs.sv]
// configuration register file behind the apb-style port
// depends on wfps_pkg for the register map and cfg_t
module wfps_regs import wfps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint_distance   <= RST_SETPOINT;
			cfg_q.predict_horizon     <= RST_HORIZON;
			cfg_q.gain_p              <= RST_GAIN_P;
			cfg_q.gain_d              <= RST_GAIN_D;
			cfg_q.gain_i              <= RST_GAIN_I;
			cfg_q.moving_threshold_sq <= RST_MOVE_THR;
			cfg_q.window_start        <= RST_WIN_START;
			cfg_q.window_end          <= RST_WIN_END;
		end else if (psel && penable && pwrite && pready) begin
			case (idx)
				REG_SETPOINT:  cfg_q.setpoint_distance   <= pwdata[15:0];
				REG_HORIZON:   cfg_q.predict_horizon     <= pwdata[7:0];
				REG_GAIN_P:    cfg_q.gain_p              <= pwdata[15:0];
				REG_GAIN_D:    cfg_q.gain_d              <= pwdata[15:0];
				REG_GAIN_I:    cfg_q.gain_i              <= pwdata[15:0];
				REG_MOVE_THR:  cfg_q.moving_threshold_sq <= pwdata;
				REG_WIN_START: cfg_q.window_start        <= pwdata[WIN_W-1:0];
				REG_WIN_END:   cfg_q.window_end          <= pwdata[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SETPOINT:  prdata = DATA_W'(cfg_q.setpoint_distance);
			REG_HORIZON:   prdata = DATA_W'(cfg_q.predict_horizon);
			REG_GAIN_P:    prdata = DATA_W'(cfg_q.gain_p);
			REG_GAIN_D:    prdata = DATA_W'(cfg_q.gain_d);
			REG_GAIN_I:    prdata = DATA_W'(cfg_q.gain_i);
			REG_MOVE_THR:  prdata = cfg_q.moving_threshold_sq;
			REG_WIN_START: prdata = DATA_W'(cfg_q.window_start);
			REG_WIN_END:   prdata = DATA_W'(cfg_q.window_end);
			default:       prdata = '0;
		endcase
	end

endmodule

[hdl/wfps_ctrl.sv]
// controller state machine: input handshake and control step sequencing
// depends on wfps_pkg for state_t, dp_cmd_t and dp_status_t
module wfps_ctrl import wfps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       action,
	input  logic       last_sample,
	input  dp_status_t status,
	output logic       in_stall,
	output dp_cmd_t    cmd
);

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	state_t               state_q, state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				div_cnt_q <= (div_cnt_q == DIV_LAST) ? '0 : div_cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (action) begin
						cmd.odom_ld = 1'b1;
						state_d     = ST_ODOM;
					end else begin
						cmd.sample = 1'b1;
						if (last_sample) begin
							state_d = ST_PRED;
						end
					end
				end
			end
			ST_ODOM: begin
				cmd.odom_cmp = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_PRED: begin
				cmd.pred = 1'b1;
				state_d  = ST_ERR;
			end
			ST_ERR: begin
				cmd.err = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_IMUL;
			end
			ST_IMUL: begin
				cmd.imul = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_LAST) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				if (!status.out_full) begin
					cmd.sum = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[hdl/wfps_dp.sv]
// datapath: window minimum, moving flag, pid arithmetic and output register
// depends on wfps_pkg for cfg_t, dp_cmd_t, dp_status_t and divider constants
module wfps_dp import wfps_pkg::*; #(
	parameter int MAX_SCAN_SAMPLES = DEF_MAX_SCAN_SAMPLES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	input  cfg_t               cfg,
	input  logic [15:0]        range_sample,
	input  logic signed [15:0] vel_x,
	input  logic signed [15:0] vel_y,
	input  logic               out_stall,
	output dp_status_t         status,
	output logic               out_valid,
	output logic signed [15:0] steer_command,
	output logic [15:0]        wall_distance,
	output logic               window_empty
);

	localparam int IDX_W = $clog2(MAX_SCAN_SAMPLES + 1);
	localparam int CMP_W = (IDX_W > WIN_W) ? IDX_W : WIN_W;
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_SCAN_SAMPLES);
	localparam int PROD_W = 26;
	localparam int ERR_W  = 24;
	localparam int DERR_W = 25;
	localparam int P_W    = 40;
	localparam int I_W    = 49;
	localparam int SUM_W  = 51;
	localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(64'sd1 << 20);
	localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_HI;

	// one radix-64 digit of the divide by the derivative constant
	function automatic logic [DIV_REM_W+DIV_DIGIT_W-1:0] div_digit(
		input logic [DIV_REM_W-1:0]   rem,
		input logic [DIV_DIGIT_W-1:0] bits
	);
		logic [DIV_REM_W:0]     t;
		logic [DIV_REM_W-1:0]   r;
		logic [DIV_DIGIT_W-1:0] q;
		r = rem;
		q = '0;
		for (int k = DIV_DIGIT_W - 1; k >= 0; k--) begin
			t = {r, bits[k]};
			if (t >= (DIV_REM_W+1)'(DERIV_DIV)) begin
				q[k] = 1'b1;
				r    = DIV_REM_W'(t - (DIV_REM_W+1)'(DERIV_DIV));
			end else begin
				r = t[DIV_REM_W-1:0];
			end
		end
		return {r, q};
	endfunction

	// architectural state
	logic                     is_moving_q;
	logic [IDX_W-1:0]         sample_idx_q;
	logic [15:0]              running_min_q;
	logic                     window_hit_q;
	logic [15:0]              prev_min_q;
	logic signed [ERR_W-1:0]  prev_err_q;
	logic signed [31:0]       integral_q;
	logic                     out_valid_q;

	// working registers
	logic signed [31:0]       sqx_q, sqy_q;
	logic [15:0]              cur_min_q;
	logic                     empty_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [P_W-1:0]    p_q;
	logic signed [DIV_W-1:0]  d_q;
	logic signed [I_W-1:0]    i_q;
	logic signed [SUM_W-1:0]  pi_q;
	logic [DIV_W-1:0]         div_mag_q;
	logic [DIV_W-1:0]         div_quo_q;
	logic [DIV_REM_W-1:0]     div_rem_q;
	logic                     d_neg_q;
	logic signed [15:0]       steer_q;
	logic [15:0]              wall_q;
	logic                     empty_out_q;

	logic                     in_win;
	logic [15:0]              cur_min;
	logic signed [16:0]       delta;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] err_w;
	logic signed [DERR_W-1:0] derr;
	logic signed [P_W-1:0]    p_w;
	logic signed [DIV_W-1:0]  d_w;
	logic signed [32:0]       int_sum;
	logic signed [31:0]       int_sat;
	logic signed [I_W-1:0]    i_w;
	logic [32:0]              sq_sum;
	logic [DIV_REM_W+DIV_DIGIT_W-1:0] digit;
	logic signed [SUM_W-1:0]  dq;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  sum_c;
	logic signed [SUM_W-1:0]  sum_sh;

	assign in_win = (sample_idx_q != IDX_MAX)
		&& (CMP_W'(sample_idx_q) >= CMP_W'(cfg.window_start))
		&& (CMP_W'(sample_idx_q) < CMP_W'(cfg.window_end));

	assign cur_min = window_hit_q ? running_min_q : prev_min_q;
	assign delta   = $signed({1'b0, cur_min}) - $signed({1'b0, prev_min_q});
	assign prod    = $signed({1'b0, cfg.predict_horizon}) * delta;

	assign err_w = $signed(PROD_W'(cfg.setpoint_distance)) - $signed(PROD_W'(cur_min_q))
		- (prod_q >>> 4);

	assign derr = DERR_W'(err_q) - DERR_W'(prev_err_q);
	assign p_w  = $signed({1'b0, cfg.gain_p}) * err_q;
	assign d_w  = $signed({1'b0, cfg.gain_d}) * derr;

	assign int_sum = 33'(integral_q) + 33'(err_q);
	always_comb begin
		if (int_sum[32] != int_sum[31]) begin
			int_sat = int_sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
		end else begin
			int_sat = int_sum[31:0];
		end
	end

	assign i_w    = $signed({1'b0, cfg.gain_i}) * integral_q;
	assign sq_sum = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign digit  = div_digit(div_rem_q, div_mag_q[DIV_W-1 -: DIV_DIGIT_W]);

	assign dq  = d_neg_q ? -$signed(SUM_W'(div_quo_q)) : $signed(SUM_W'(div_quo_q));
	assign sum = pi_q + dq;
	always_comb begin
		if (sum > SUM_HI) begin
			sum_c = SUM_HI;
		end else if (sum < SUM_LO) begin
			sum_c = SUM_LO;
		end else begin
			sum_c = sum;
		end
	end
	assign sum_sh = sum_c >>> 6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_moving_q   <= 1'b0;
			sample_idx_q  <= '0;
			running_min_q <= '1;
			window_hit_q  <= 1'b0;
			prev_min_q    <= '0;
			prev_err_q    <= '0;
			integral_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.sample) begin
				if (in_win) begin
					if (!window_hit_q || range_sample < running_min_q) begin
						running_min_q <= range_sample;
					end
					window_hit_q <= 1'b1;
				end
				if (sample_idx_q != IDX_MAX) begin
					sample_idx_q <= sample_idx_q + 1'b1;
				end
			end
			if (cmd.odom_cmp) begin
				is_moving_q <= sq_sum > {1'b0, cfg.moving_threshold_sq};
			end
			if (cmd.pred) begin
				prev_min_q    <= cur_min;
				sample_idx_q  <= '0;
				running_min_q <= '1;
				window_hit_q  <= 1'b0;
			end
			if (cmd.mul) begin
				prev_err_q <= err_q;
				if (is_moving_q) begin
					integral_q <= int_sat;
				end
			end
			if (cmd.sum) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.odom_ld) begin
			sqx_q <= vel_x * vel_x;
			sqy_q <= vel_y * vel_y;
		end
		if (cmd.pred) begin
			cur_min_q <= cur_min;
			empty_q   <= !window_hit_q;
			prod_q    <= prod;
		end
		if (cmd.err) begin
			err_q <= err_w[ERR_W-1:0];
		end
		if (cmd.mul) begin
			p_q <= p_w;
			d_q <= d_w;
		end
		if (cmd.imul) begin
			i_q       <= i_w;
			d_neg_q   <= d_q[DIV_W-1];
			div_mag_q <= d_q[DIV_W-1] ? DIV_W'(-d_q) : DIV_W'(d_q);
			div_quo_q <= '0;
			div_rem_q <= '0;
		end
		if (cmd.div_step) begin
			pi_q      <= SUM_W'(p_q) + SUM_W'(i_q);
			div_mag_q <= div_mag_q << DIV_DIGIT_W;
			div_quo_q <= {div_quo_q[DIV_W-DIV_DIGIT_W-1:0], digit[DIV_DIGIT_W-1:0]};
			div_rem_q <= digit[DIV_REM_W+DIV_DIGIT_W-1:DIV_DIGIT_W];
		end
		if (cmd.sum) begin
			steer_q     <= sum_sh[15:0];
			wall_q      <= cur_min_q;
			empty_out_q <= empty_q;
		end
	end

	assign status.out_full = out_valid_q && out_stall;
	assign out_valid       = out_valid_q;
	assign steer_command   = steer_q;
	assign wall_distance   = wall_q;
	assign window_empty    = empty_out_q;

endmodule

[hdl/wall_follow_pid_steering.sv]
// Wall-following pid steering block. While the controller is idle, range samples that
// are not the last of a scan stream in at one word per clock. An odometry word squares
// the velocities, then compares their sum against the speed threshold. The last sample
// of a scan runs through the sample itself, prediction, error, the p and d products
// with the integral update, the i product, the digit steps of the radix-64 divider
// for the derivative constant, and the final sum and clamp; the sum waits further
// while the previous result is still held in the output register. The result word
// sits in that register, so new samples are accepted while it waits to be taken.
// top level: apb-style register file, controller and datapath
// depends on wfps_pkg, wfps_regs, wfps_ctrl and wfps_dp
module wall_follow_pid_steering import wfps_pkg::*; #(
	parameter int MAX_SCAN_SAMPLES = DEF_MAX_SCAN_SAMPLES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic [15:0]        range_sample,
	input  logic               last_sample,
	input  logic signed [15:0] vel_x,
	input  logic signed [15:0] vel_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] steer_command,
	output logic [15:0]        wall_distance,
	output logic               window_empty
);

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	wfps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wfps_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.action      (action),
		.last_sample (last_sample),
		.status      (status),
		.in_stall    (in_stall),
		.cmd         (cmd)
	);

	wfps_dp #(
		.MAX_SCAN_SAMPLES (MAX_SCAN_SAMPLES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg           (cfg),
		.range_sample  (range_sample),
		.vel_x         (vel_x),
		.vel_y         (vel_y),
		.out_stall     (out_stall),
		.status        (status),
		.out_valid     (out_valid),
		.steer_command (steer_command),
		.wall_distance (wall_distance),
		.window_empty  (window_empty)
	);

	a_steer_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (steer_command <= 16'sd16384 && steer_command >= -16'sd16384))
		else $error("steering word outside unit range");

	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !action && last_sample |=> in_stall)
		else $error("input not stalled after end of scan");

	a_odom_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action |=> in_stall)
		else $error("input not stalled after odometry word");

	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result produced without a control step");

endmodule
